[src/stn_pkg.sv]
// Shared types, constants and functions of the search text normalizer.
// Holds the case fold range table and the separator classifier.
// Depends on nothing; used by search_text_normalizer.
`default_nettype none

package stn_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] SURR_HIGH_FIRST = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HIGH_LAST  = 21'h00DBFF;
    localparam logic [CP_W-1:0] SURR_LOW_FIRST  = 21'h00DC00;
    localparam logic [CP_W-1:0] SURR_LOW_LAST   = 21'h00DFFF;
    localparam logic [CP_W-1:0] SUPP_BASE       = 21'h010000;
    localparam logic [CP_W-1:0] SPACE_CP        = 21'h000020;
    localparam logic [CP_W-1:0] MARKER_CP       = 21'h000000;

    // One result item as it sits in the output buffer.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            has_char;
        logic            run_last;
        logic            text_done;
    } result_t;

    function automatic logic in_range(input logic [CP_W-1:0] v,
                                      input logic [CP_W-1:0] lo,
                                      input logic [CP_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Simple case folding by the fixed range table.
    function automatic logic [CP_W-1:0] fold(input logic [CP_W-1:0] v);
        logic [CP_W-1:0] r;
        r = v;
        priority if (in_range(v, 21'h41, 21'h5A)) begin
            r = v + 21'h20;
        end else if (in_range(v, 21'hC0, 21'hD6) || in_range(v, 21'hD8, 21'hDE)) begin
            r = v + 21'h20;
        end else if (in_range(v, 21'h100, 21'h12F) && !v[0]) begin
            r = v + 21'h1;
        end else if (in_range(v, 21'h132, 21'h137) && !v[0]) begin
            r = v + 21'h1;
        end else if (in_range(v, 21'h139, 21'h148) && v[0]) begin
            r = v + 21'h1;
        end else if (in_range(v, 21'h14A, 21'h177) && !v[0]) begin
            r = v + 21'h1;
        end else if (in_range(v, 21'h179, 21'h17E) && v[0]) begin
            r = v + 21'h1;
        end else if (in_range(v, 21'h391, 21'h3A1)) begin
            r = v + 21'h20;
        end else if (in_range(v, 21'h3A3, 21'h3AB)) begin
            r = v + 21'h20;
        end else if (v == 21'h3C2) begin
            r = 21'h3C3;
        end else if (in_range(v, 21'h400, 21'h40F)) begin
            r = v + 21'h50;
        end else if (in_range(v, 21'h410, 21'h42F)) begin
            r = v + 21'h20;
        end else if (in_range(v, 21'h460, 21'h481) && !v[0]) begin
            r = v + 21'h1;
        end else if (in_range(v, 21'h531, 21'h556)) begin
            r = v + 21'h30;
        end else if (in_range(v, 21'h1C90, 21'h1CBF)) begin
            r = v - 21'hBC0;
        end else if (in_range(v, 21'hFF21, 21'hFF3A)) begin
            r = v + 21'h20;
        end else if (in_range(v, 21'h10400, 21'h10427)) begin
            r = v + 21'h28;
        end else if (v == 21'h130) begin
            r = 21'h69;
        end else if (v == 21'h178) begin
            r = 21'hFF;
        end else if (v == 21'h1E9E) begin
            r = 21'hDF;
        end else if (v == 21'h2126) begin
            r = 21'h3C9;
        end else if (v == 21'h212A) begin
            r = 21'h6B;
        end else if (v == 21'h212B) begin
            r = 21'hE5;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Separator classes: ASCII non-alphanumerics, listed spaces and punctuation blocks.
    function automatic logic is_sep(input logic [CP_W-1:0] v);
        logic ascii_alnum;
        ascii_alnum = in_range(v, 21'h61, 21'h7A) || in_range(v, 21'h41, 21'h5A) ||
                      in_range(v, 21'h30, 21'h39);
        if (v <= 21'h7F) begin
            return !ascii_alnum;
        end
        return (v == 21'h85) || (v == 21'hA0) || (v == 21'h1680) || (v == 21'h180E) ||
               (v == 21'h3000) || (v == 21'hFEFF) ||
               in_range(v, 21'h2000, 21'h206F) || in_range(v, 21'h2E00, 21'h2E7F) ||
               in_range(v, 21'h3001, 21'h303F) || in_range(v, 21'hFE10, 21'hFE1F) ||
               in_range(v, 21'hFE30, 21'hFE4F) || in_range(v, 21'hFF01, 21'hFF0F) ||
               in_range(v, 21'hFF1A, 21'hFF20) || in_range(v, 21'hFF3B, 21'hFF40) ||
               in_range(v, 21'hFF5B, 21'hFF65);
    endfunction

endpackage

`default_nettype wire

[src/search_text_normalizer.sv]
// Search text normalizer: input register, one pass of fold and separator logic, and a
// three entry result buffer; uses stn_pkg for the fold table and types.
// A unit passes through the input register and then the result buffer before it can transfer.
// Throughput: one item per cycle while items yield one result each and m_ready holds; an item
// with several results fills the buffer and the next item waits in the input register meanwhile.
// Reset (aresetn low, synchronous): buffers empty, text state cleared, pairing enabled.
`default_nettype none

module search_text_normalizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [20:0] s_code_unit,
    input  wire logic        s_text_end,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [20:0]      m_code_point,
    output logic             m_has_char,
    output logic             m_run_last,
    output logic             m_text_done
);

    localparam int unsigned CP_W = stn_pkg::CP_W;

    logic            pair_reg;

    logic            in_valid_reg;
    logic [CP_W-1:0] in_unit_reg;
    logic            in_end_reg;

    logic [15:0]     held_high_reg, held_high_next;
    logic            held_valid_reg, held_valid_next;
    logic            space_pending_reg, space_pending_next;
    logic            any_emitted_reg, any_emitted_next;

    stn_pkg::result_t buf_reg [3];
    logic [1:0]       cnt_reg;

    stn_pkg::result_t res [3];
    logic [1:0]       res_cnt;

    logic            pop, advance, buf_free;
    logic            join_pair, hold_new, a_en, b_en;
    logic [CP_W-1:0] held_cp, b_val, f_a, f_b;
    logic            sep_a, sep_b;
    logic            sp_a, ch_a, sp_b, ch_b;
    logic            sp1, ae1;
    logic [3:0]      emit_en;
    logic [CP_W-1:0] emit_cp [4];

    assign cfg_ready = 1'b1;

    assign pop      = m_valid && m_ready;
    assign buf_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign advance  = in_valid_reg && buf_free;
    assign s_ready  = !in_valid_reg || advance;

    assign m_valid      = (cnt_reg != 2'd0);
    assign m_code_point = buf_reg[0].code_point;
    assign m_has_char   = buf_reg[0].has_char;
    assign m_run_last   = buf_reg[0].run_last;
    assign m_text_done  = buf_reg[0].text_done;

    // Decide which units are taken: a flushed high surrogate (A) and the current unit (B).
    always_comb begin
        held_cp   = {5'd0, held_high_reg};
        join_pair = pair_reg && held_valid_reg &&
                    stn_pkg::in_range(in_unit_reg, stn_pkg::SURR_LOW_FIRST,
                                      stn_pkg::SURR_LOW_LAST);
        hold_new  = pair_reg && !join_pair && !in_end_reg &&
                    stn_pkg::in_range(in_unit_reg, stn_pkg::SURR_HIGH_FIRST,
                                      stn_pkg::SURR_HIGH_LAST);
        a_en      = held_valid_reg && !join_pair;
        b_en      = !hold_new;
        b_val     = join_pair ?
                    (stn_pkg::SUPP_BASE + {1'b0, held_high_reg[9:0], in_unit_reg[9:0]}) :
                    in_unit_reg;
        f_a   = stn_pkg::fold(held_cp);
        f_b   = stn_pkg::fold(b_val);
        sep_a = stn_pkg::is_sep(f_a);
        sep_b = stn_pkg::is_sep(f_b);
    end

    // Separator run tracking across the two takes.
    always_comb begin
        sp_a = 1'b0;
        ch_a = 1'b0;
        sp1  = space_pending_reg;
        ae1  = any_emitted_reg;
        if (a_en) begin
            if (sep_a) begin
                sp1 = any_emitted_reg;
            end else begin
                sp_a = space_pending_reg;
                ch_a = 1'b1;
                sp1  = 1'b0;
                ae1  = 1'b1;
            end
        end
        sp_b               = 1'b0;
        ch_b               = 1'b0;
        space_pending_next = sp1;
        any_emitted_next   = ae1;
        if (b_en) begin
            if (sep_b) begin
                space_pending_next = ae1;
            end else begin
                sp_b               = sp1;
                ch_b               = 1'b1;
                space_pending_next = 1'b0;
                any_emitted_next   = 1'b1;
            end
        end
        held_valid_next = hold_new;
        held_high_next  = hold_new ? in_unit_reg[15:0] : 16'd0;
        if (in_end_reg) begin
            space_pending_next = 1'b0;
            any_emitted_next   = 1'b0;
            held_valid_next    = 1'b0;
            held_high_next     = 16'd0;
        end
    end

    // Pack the emitted code points into consecutive buffer slots.
    always_comb begin
        emit_en    = {ch_b, sp_b, ch_a, sp_a};
        emit_cp[0] = stn_pkg::SPACE_CP;
        emit_cp[1] = f_a;
        emit_cp[2] = stn_pkg::SPACE_CP;
        emit_cp[3] = f_b;
        res_cnt    = 2'd0;
        for (int i = 0; i < 3; i++) begin
            res[i] = '{code_point: stn_pkg::MARKER_CP, has_char: 1'b0,
                       run_last: 1'b0, text_done: 1'b0};
        end
        for (int k = 0; k < 4; k++) begin
            if (emit_en[k] && (res_cnt != 2'd3)) begin
                res[res_cnt].code_point = emit_cp[k];
                res[res_cnt].has_char   = 1'b1;
                res_cnt                 = res_cnt + 2'd1;
            end
        end
        // A text end that produced nothing still sends a bare marker.
        if (in_end_reg && (res_cnt == 2'd0)) begin
            res_cnt = 2'd1;
        end
        for (int i = 0; i < 3; i++) begin
            if (res_cnt == 2'(i + 1)) begin
                res[i].run_last  = 1'b1;
                res[i].text_done = in_end_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg          <= 1'b1;
            in_valid_reg      <= 1'b0;
            held_high_reg     <= 16'd0;
            held_valid_reg    <= 1'b0;
            space_pending_reg <= 1'b0;
            any_emitted_reg   <= 1'b0;
            cnt_reg           <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                pair_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                held_high_reg     <= held_high_next;
                held_valid_reg    <= held_valid_next;
                space_pending_reg <= space_pending_next;
                any_emitted_reg   <= any_emitted_next;
                cnt_reg           <= res_cnt;
            end else if (pop) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_unit_reg <= s_code_unit;
            in_end_reg  <= s_text_end;
        end
        if (advance) begin
            buf_reg[0] <= res[0];
            buf_reg[1] <= res[1];
            buf_reg[2] <= res[2];
        end else if (pop) begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

endmodule

`default_nettype wire

[src/stn_checker.sv]
// Port-level checks for the search text normalizer, attached by bind.
// Depends on search_text_normalizer's port list.
`default_nettype none

module stn_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [20:0] m_code_point,
    input wire logic        m_has_char,
    input wire logic        m_run_last,
    input wire logic        m_text_done
);

    // A stalled result transfer keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_point) && $stable(m_has_char) &&
                                $stable(m_run_last) && $stable(m_text_done))
        else $error("result changed while stalled");

    // The end of a text is always the last result of its item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_text_done |-> m_run_last)
        else $error("text_done without run_last");

    // A bare marker only closes a text and carries a zero code point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_char |-> m_text_done && (m_code_point == 21'h0))
        else $error("bare marker outside text end");

    // A collapsed space is always followed by a character from the same item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_last && m_has_char |-> m_code_point != 21'h20)
        else $error("separator space ends an item");

endmodule

bind search_text_normalizer stn_checker u_stn_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_code_point (m_code_point),
    .m_has_char   (m_has_char),
    .m_run_last   (m_run_last),
    .m_text_done  (m_text_done)
);

`default_nettype wire
